>>> sv/scf_pkg.sv
// Shared types, constants and saturation helpers for the stereo crossfeed block.
package scf_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 28;

    localparam int STATE_W   = 32;
    localparam int GAIN_W    = 29;
    localparam int CFG_W     = 32;
    localparam int REG_IDX_W = 3;
    localparam int MUL_W     = STATE_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CNT_W     = 4;
    localparam int NUM_COEF  = 6;

    // last step of one item: products issued on 0..8, 10 and 11, last one retired on 12
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(12);

    localparam logic [REG_IDX_W-1:0] REG_COEF_A0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_A2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIX_B0   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIX_B1   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIX_B2   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_IN  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_OUT = 3'd7;

    localparam logic signed [PROD_W-1:0] STATE_MAX =
        {{(PROD_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] STATE_MIN = ~STATE_MAX;

    typedef enum logic [3:0] {
        OP_MID,
        OP_SIDE,
        OP_A0I1,
        OP_A1I1,
        OP_A1V3,
        OP_A2V3,
        OP_B0V0,
        OP_B1V1,
        OP_B2V2,
        OP_GL,
        OP_GR
    } op_t;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_RUN,
        CT_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic issue;
        op_t  issue_op;
        logic post;
        op_t  post_op;
        logic deliver;
    } cmd_t;

    function automatic logic signed [PROD_W-1:0] sx_state(input logic signed [STATE_W-1:0] v);
        return PROD_W'(v);
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [PROD_W-1:0] v);
        logic signed [STATE_W-1:0] res;
        if (v > STATE_MAX) begin
            res = STATE_MAX[STATE_W-1:0];
        end else if (v < STATE_MIN) begin
            res = STATE_MIN[STATE_W-1:0];
        end else begin
            res = v[STATE_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/scf_ctrl.sv
// Sequencer for the shared multiplier and the output handshake.
module scf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output scf_pkg::cmd_t cmd
);

    scf_pkg::ctrl_state_t state_reg, state_next;
    logic [scf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic        post_reg, post_next;
    scf_pkg::op_t post_op_reg, post_op_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scf_pkg::CT_IDLE;
            cnt_reg     <= '0;
            post_reg    <= 1'b0;
            post_op_reg <= scf_pkg::OP_MID;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            post_reg    <= post_next;
            post_op_reg <= post_op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            scf_pkg::CT_IDLE: begin
                if (s_tvalid) state_next = scf_pkg::CT_RUN;
            end
            scf_pkg::CT_RUN: begin
                if (cnt_reg == scf_pkg::LAST_STEP) state_next = scf_pkg::CT_DONE;
            end
            scf_pkg::CT_DONE: begin
                if (out_free) state_next = scf_pkg::CT_IDLE;
            end
            default: state_next = scf_pkg::CT_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.issue_op = scf_pkg::OP_MID;
        cmd.post     = post_reg;
        cmd.post_op  = post_op_reg;
        cnt_next     = cnt_reg;
        case (state_reg)
            scf_pkg::CT_IDLE: begin
                // no item is taken while reset is held
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
                cnt_next = '0;
            end
            scf_pkg::CT_RUN: begin
                cnt_next  = cnt_reg + 1'b1;
                cmd.issue = 1'b1;
                // step 9 is a bubble: filtered side retires before the gain_out products
                case (cnt_reg)
                    4'd0:    cmd.issue_op = scf_pkg::OP_MID;
                    4'd1:    cmd.issue_op = scf_pkg::OP_SIDE;
                    4'd2:    cmd.issue_op = scf_pkg::OP_A0I1;
                    4'd3:    cmd.issue_op = scf_pkg::OP_A1I1;
                    4'd4:    cmd.issue_op = scf_pkg::OP_A1V3;
                    4'd5:    cmd.issue_op = scf_pkg::OP_A2V3;
                    4'd6:    cmd.issue_op = scf_pkg::OP_B0V0;
                    4'd7:    cmd.issue_op = scf_pkg::OP_B1V1;
                    4'd8:    cmd.issue_op = scf_pkg::OP_B2V2;
                    4'd10:   cmd.issue_op = scf_pkg::OP_GL;
                    4'd11:   cmd.issue_op = scf_pkg::OP_GR;
                    default: cmd.issue    = 1'b0;
                endcase
            end
            scf_pkg::CT_DONE: begin
                cmd.deliver = out_free;
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    assign post_next    = cmd.issue;
    assign post_op_next = cmd.issue_op;
    assign m_valid_next = cmd.deliver ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    assign m_tvalid     = m_valid_reg;

endmodule

>>> sv/scf_datapath.sv
// Registers, shared multiplier, rounding and accumulation for the crossfeed filter.
module scf_datapath #(
    parameter int SAMPLE_BITS    = scf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = scf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  scf_pkg::cmd_t                          cmd,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_data,
    input  logic                                   in_bypass,
    input  logic                                   cfg_wr_en,
    input  logic [scf_pkg::REG_IDX_W-1:0]          cfg_wr_index,
    input  logic [scf_pkg::CFG_W-1:0]              cfg_wr_data,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     out_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int DATA_W = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int MW     = scf_pkg::MUL_W;
    localparam int PW     = scf_pkg::PROD_W;
    localparam int SW     = scf_pkg::STATE_W;
    localparam int GW     = scf_pkg::GAIN_W;

    localparam logic [scf_pkg::CFG_W-1:0] COEF_UNITY = scf_pkg::CFG_W'(1) << COEF_FRAC_BITS;
    localparam logic [GW-1:0]             GAIN_UNITY = GW'(1) << COEF_FRAC_BITS;
    localparam logic signed [PW-1:0] HALF_C = PW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [PW-1:0] HALF_G = PW'(1) << COEF_FRAC_BITS;
    localparam logic signed [PW-1:0] SAMP_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [PW-1:0] SAMP_MIN = ~SAMP_MAX;

    logic signed [scf_pkg::CFG_W-1:0] coef_reg [scf_pkg::NUM_COEF];
    logic [GW-1:0]        gain_in_reg, gain_out_reg;
    logic signed [SW-1:0] integ_one_reg, integ_two_reg;

    logic signed [SB-1:0] left_reg, right_reg, res_left_reg, res_right_reg;
    logic                 bypass_reg;
    logic signed [SW-1:0] mid_reg, side_reg, v1_reg, v2_reg, v3_reg, fside_reg;
    logic signed [PW-1:0] acc1_reg, acc2_reg, prod_reg;
    logic [DATA_W-1:0]    out_data_reg;

    logic signed [MW-1:0] left_x, right_x, op_a, op_b;
    logic signed [PW-1:0] rnd_c, rnd_g, rnd;
    logic signed [SB-1:0] sat_samp;
    logic [DATA_W-1:0]    pack;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0]  <= COEF_UNITY;
            coef_reg[1]  <= '0;
            coef_reg[2]  <= '0;
            coef_reg[3]  <= COEF_UNITY;
            coef_reg[4]  <= '0;
            coef_reg[5]  <= '0;
            gain_in_reg  <= GAIN_UNITY;
            gain_out_reg <= GAIN_UNITY;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                scf_pkg::REG_COEF_A0:  coef_reg[0]  <= cfg_wr_data;
                scf_pkg::REG_COEF_A1:  coef_reg[1]  <= cfg_wr_data;
                scf_pkg::REG_COEF_A2:  coef_reg[2]  <= cfg_wr_data;
                scf_pkg::REG_MIX_B0:   coef_reg[3]  <= cfg_wr_data;
                scf_pkg::REG_MIX_B1:   coef_reg[4]  <= cfg_wr_data;
                scf_pkg::REG_MIX_B2:   coef_reg[5]  <= cfg_wr_data;
                scf_pkg::REG_GAIN_IN:  gain_in_reg  <= cfg_wr_data[GW-1:0];
                scf_pkg::REG_GAIN_OUT: gain_out_reg <= cfg_wr_data[GW-1:0];
                default: ;
            endcase
        end
    end

    assign left_x  = MW'(left_reg);
    assign right_x = MW'(right_reg);

    // multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.issue_op)
            scf_pkg::OP_MID:  begin op_a = left_x + right_x; op_b = MW'(gain_in_reg); end
            scf_pkg::OP_SIDE: begin op_a = left_x - right_x; op_b = MW'(gain_in_reg); end
            scf_pkg::OP_A0I1: begin op_a = MW'(coef_reg[0]); op_b = MW'(integ_one_reg); end
            scf_pkg::OP_A1I1: begin op_a = MW'(coef_reg[1]); op_b = MW'(integ_one_reg); end
            scf_pkg::OP_A1V3: begin op_a = MW'(coef_reg[1]); op_b = MW'(v3_reg); end
            scf_pkg::OP_A2V3: begin op_a = MW'(coef_reg[2]); op_b = MW'(v3_reg); end
            scf_pkg::OP_B0V0: begin op_a = MW'(coef_reg[3]); op_b = MW'(side_reg); end
            scf_pkg::OP_B1V1: begin op_a = MW'(coef_reg[4]); op_b = MW'(v1_reg); end
            scf_pkg::OP_B2V2: begin op_a = MW'(coef_reg[5]); op_b = MW'(v2_reg); end
            scf_pkg::OP_GL: begin
                op_a = MW'(gain_out_reg);
                op_b = MW'(mid_reg) + MW'(fside_reg);
            end
            scf_pkg::OP_GR: begin
                op_a = MW'(gain_out_reg);
                op_b = MW'(mid_reg) - MW'(fside_reg);
            end
            default: ;
        endcase
    end

    // round half up, then floor; gain_in products carry the extra halving
    assign rnd_c = (prod_reg + HALF_C) >>> COEF_FRAC_BITS;
    assign rnd_g = (prod_reg + HALF_G) >>> (COEF_FRAC_BITS + 1);
    assign rnd   = (cmd.post_op == scf_pkg::OP_MID || cmd.post_op == scf_pkg::OP_SIDE)
                   ? rnd_g : rnd_c;

    always_comb begin
        if (rnd > SAMP_MAX) begin
            sat_samp = SAMP_MAX[SB-1:0];
        end else if (rnd < SAMP_MIN) begin
            sat_samp = SAMP_MIN[SB-1:0];
        end else begin
            sat_samp = rnd[SB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_one_reg <= '0;
            integ_two_reg <= '0;
        end else if (cmd.post) begin
            case (cmd.post_op)
                scf_pkg::OP_A2V3: integ_one_reg <= scf_pkg::sat_state(
                    (scf_pkg::sx_state(v1_reg) <<< 1) - scf_pkg::sx_state(integ_one_reg));
                scf_pkg::OP_B0V0: integ_two_reg <= scf_pkg::sat_state(
                    (scf_pkg::sx_state(v2_reg) <<< 1) - scf_pkg::sx_state(integ_two_reg));
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg   <= in_data[SB-1:0];
            right_reg  <= in_data[2*SB-1:SB];
            bypass_reg <= in_bypass;
        end
        if (cmd.issue) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.post) begin
            case (cmd.post_op)
                scf_pkg::OP_MID:  mid_reg  <= scf_pkg::sat_state(rnd);
                scf_pkg::OP_SIDE: side_reg <= scf_pkg::sat_state(rnd);
                scf_pkg::OP_A0I1: begin
                    acc1_reg <= rnd;
                    v3_reg   <= scf_pkg::sat_state(scf_pkg::sx_state(side_reg)
                                                   - scf_pkg::sx_state(integ_two_reg));
                end
                scf_pkg::OP_A1I1: acc2_reg  <= scf_pkg::sx_state(integ_two_reg) + rnd;
                scf_pkg::OP_A1V3: v1_reg    <= scf_pkg::sat_state(acc1_reg + rnd);
                scf_pkg::OP_A2V3: v2_reg    <= scf_pkg::sat_state(acc2_reg + rnd);
                scf_pkg::OP_B0V0: acc1_reg  <= rnd;
                scf_pkg::OP_B1V1: acc1_reg  <= acc1_reg + rnd;
                scf_pkg::OP_B2V2: fside_reg <= scf_pkg::sat_state(acc1_reg + rnd);
                scf_pkg::OP_GL:   res_left_reg  <= bypass_reg ? left_reg : sat_samp;
                scf_pkg::OP_GR:   res_right_reg <= bypass_reg ? right_reg : sat_samp;
                default: ;
            endcase
        end
        if (cmd.deliver) begin
            out_data_reg <= pack;
        end
    end

    always_comb begin
        pack              = '0;
        pack[SB-1:0]      = res_left_reg;
        pack[2*SB-1:SB]   = res_right_reg;
    end

    assign out_data = out_data_reg;

endmodule

>>> sv/stereo_crossfeed_svf_shelf.sv
// Top level of the stereo crossfeed with side-channel state-variable shelf filter.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/tready    s_tdata: left_in, right_in; s_tuser: bypass
//  m_        out        m_tvalid/tready    m_tdata: left_out, right_out
//  cfg_wr_   in         cfg_wr_en          cfg_wr_index, cfg_wr_data (no read-back)
//
// An item is taken only while the block is idle, so the block is through with one
// item before it takes the next, which is taken in the cycle after the result is
// written to the output register. 11 products share one 33x33 multiplier, one per
// cycle, with a bubble before the gain_out products.
// Synchronous active-low reset restores the register defaults and clears both
// integrators. The output register holds a result while m_tready is low; the next
// item is still taken and worked on, and waits only to write that register.
module stereo_crossfeed_svf_shelf #(
    parameter int SAMPLE_BITS    = scf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = scf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // left_in, right_in
    input  logic                                s_tuser,   // bypass
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,   // left_out, right_out
    input  logic                                cfg_wr_en,
    input  logic [scf_pkg::REG_IDX_W-1:0]       cfg_wr_index,
    input  logic [scf_pkg::CFG_W-1:0]           cfg_wr_data
);

    scf_pkg::cmd_t cmd;

    scf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    scf_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_data      (s_tdata),
        .in_bypass    (s_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .out_data     (m_tdata)
    );

endmodule

>>> tb/tb_stereo_crossfeed_svf_shelf.sv
// Self-checking testbench for the stereo crossfeed block with side-channel shelf filter.
module tb_stereo_crossfeed_svf_shelf;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W    = scf_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC_W      = scf_pkg::COEF_FRAC_BITS_DEF;
    localparam int DATA_W      = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 24;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 53;

    // Bit-true model of the crossfeed datapath plus the queue of expected pairs.
    class crossfeed_scoreboard;
        longint coef[scf_pkg::NUM_COEF];
        longint gain_in;
        longint gain_out;
        longint integ1;
        longint integ2;
        logic [DATA_W-1:0] pending_q[$];
        int errors;

        function new();
            coef[scf_pkg::REG_COEF_A0] = longint'(1) << FRAC_W;
            coef[scf_pkg::REG_COEF_A1] = 0;
            coef[scf_pkg::REG_COEF_A2] = 0;
            coef[scf_pkg::REG_MIX_B0]  = longint'(1) << FRAC_W;
            coef[scf_pkg::REG_MIX_B1]  = 0;
            coef[scf_pkg::REG_MIX_B2]  = 0;
            gain_in  = longint'(1) << FRAC_W;
            gain_out = longint'(1) << FRAC_W;
            integ1 = 0;
            integ2 = 0;
            errors = 0;
        endfunction

        function void set_register(logic [scf_pkg::REG_IDX_W-1:0] idx,
                                   logic [scf_pkg::CFG_W-1:0] val);
            case (idx)
                scf_pkg::REG_GAIN_IN:  gain_in = longint'(val[scf_pkg::GAIN_W-1:0]);
                scf_pkg::REG_GAIN_OUT: gain_out = longint'(val[scf_pkg::GAIN_W-1:0]);
                default:               coef[idx] = longint'($signed(val));
            endcase
        endfunction

        // round half up, then floor shift
        function longint rnd_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function longint clip(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) << (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        function longint cmul(longint c, longint x);
            return rnd_shift(c * x, FRAC_W);
        endfunction

        function void note_pair(logic signed [SAMPLE_W-1:0] l_in,
                                logic signed [SAMPLE_W-1:0] r_in, logic byp);
            longint l, r, mid, side, v1, v2, v3, fside, ol, orr;
            l = l_in;
            r = r_in;
            mid  = clip(rnd_shift((l + r) * gain_in, FRAC_W + 1), scf_pkg::STATE_W);
            side = clip(rnd_shift((l - r) * gain_in, FRAC_W + 1), scf_pkg::STATE_W);
            v3 = clip(side - integ2, scf_pkg::STATE_W);
            v1 = clip(cmul(coef[scf_pkg::REG_COEF_A0], integ1)
                      + cmul(coef[scf_pkg::REG_COEF_A1], v3), scf_pkg::STATE_W);
            v2 = clip(integ2 + cmul(coef[scf_pkg::REG_COEF_A1], integ1)
                      + cmul(coef[scf_pkg::REG_COEF_A2], v3), scf_pkg::STATE_W);
            integ1 = clip(2 * v1 - integ1, scf_pkg::STATE_W);
            integ2 = clip(2 * v2 - integ2, scf_pkg::STATE_W);
            fside = clip(cmul(coef[scf_pkg::REG_MIX_B0], side)
                         + cmul(coef[scf_pkg::REG_MIX_B1], v1)
                         + cmul(coef[scf_pkg::REG_MIX_B2], v2), scf_pkg::STATE_W);
            if (byp) begin
                ol  = l;
                orr = r;
            end else begin
                ol  = clip(cmul(gain_out, mid + fside), SAMPLE_W);
                orr = clip(cmul(gain_out, mid - fside), SAMPLE_W);
            end
            pending_q.push_back({orr[SAMPLE_W-1:0], ol[SAMPLE_W-1:0]});
        endfunction

        function void flag(string what, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch %0d: %s expected %0d got %0d",
                         errors, what, $signed(want), $signed(got));
        endfunction

        function void check_pair(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch %0d: result with nothing expected, data %h", errors, got);
                return;
            end
            want = pending_q.pop_front();
            if (got[SAMPLE_W-1:0] !== want[SAMPLE_W-1:0])
                flag("left_out", want[SAMPLE_W-1:0], got[SAMPLE_W-1:0]);
            if (got[2*SAMPLE_W-1:SAMPLE_W] !== want[2*SAMPLE_W-1:SAMPLE_W])
                flag("right_out", want[2*SAMPLE_W-1:SAMPLE_W], got[2*SAMPLE_W-1:SAMPLE_W]);
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [DATA_W-1:0]             s_tdata = '0;    // left_in, right_in
    logic                          s_tuser = 1'b0;  // bypass
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [DATA_W-1:0]             m_tdata;         // left_out, right_out
    logic                          cfg_wr_en = 1'b0;
    logic [scf_pkg::REG_IDX_W-1:0] cfg_wr_index = '0;
    logic [scf_pkg::CFG_W-1:0]     cfg_wr_data = '0;

    crossfeed_scoreboard sb;
    bit tx_busy = 1'b0;
    bit rx_busy = 1'b0;
    bit long_hold_req = 1'b0;

    stereo_crossfeed_svf_shelf dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap(bit busy);
        int pick;
        if (!busy) return 0;
        pick = int'($urandom_range(0, 99));
        if (pick < 55) return 0;
        if (pick < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int pick;
        logic [19:0] moderate;
        logic [3:0] tiny;
        pick = int'($urandom_range(0, 99));
        moderate = 20'($urandom);
        tiny = 4'($urandom);
        if (pick < 50) return {{(SAMPLE_W-20){moderate[19]}}, moderate};
        if (pick < 80) return SAMPLE_W'($urandom);
        if (pick < 90) begin
            case ($urandom_range(0, 3))
                0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
                1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        return {{(SAMPLE_W-4){tiny[3]}}, tiny};
    endfunction

    // Inputs are sampled mid-cycle and change only at rising edges.
    task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                             input logic byp);
        int gap;
        gap = pick_gap(tx_busy);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'({r, l});
        s_tuser  <= byp;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sb.note_pair(l, r, byp);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [scf_pkg::REG_IDX_W-1:0] idx,
                             input logic [scf_pkg::CFG_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        sb.set_register(idx, val);
    endtask

    // kind 0: plausible crossfeed settings, 1: anything, 2: corner values
    task automatic load_settings(input int kind);
        logic [scf_pkg::CFG_W-1:0] vals[scf_pkg::NUM_COEF+2];
        if (kind == 0) begin
            vals[scf_pkg::REG_COEF_A0]  = $urandom_range(32'h0666_6666, 32'h1000_0000);
            vals[scf_pkg::REG_COEF_A1]  = $urandom_range(0, 32'h0600_0000);
            vals[scf_pkg::REG_COEF_A2]  = $urandom_range(0, 32'h0200_0000);
            vals[scf_pkg::REG_MIX_B0]   = $urandom_range(32'h0800_0000, 32'h1400_0000);
            vals[scf_pkg::REG_MIX_B1]   = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            vals[scf_pkg::REG_MIX_B2]   = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            vals[scf_pkg::REG_GAIN_IN]  = $urandom_range(32'h0400_0000, 32'h1000_0000);
            vals[scf_pkg::REG_GAIN_OUT] = $urandom_range(32'h0800_0000, 32'h1000_0000);
        end else if (kind == 1) begin
            foreach (vals[i]) vals[i] = $urandom;
        end else begin
            for (int i = 0; i < scf_pkg::NUM_COEF; i++) begin
                case ($urandom_range(0, 3))
                    0:       vals[i] = 32'h7FFF_FFFF;
                    1:       vals[i] = 32'h8000_0000;
                    2:       vals[i] = '0;
                    default: vals[i] = 32'h1000_0000;
                endcase
            end
            for (int i = scf_pkg::NUM_COEF; i < scf_pkg::NUM_COEF + 2; i++) begin
                case ($urandom_range(0, 2))
                    0:       vals[i] = {3'($urandom), 29'h0};
                    1:       vals[i] = {3'($urandom), 29'h1FFF_FFFF};
                    default: vals[i] = {3'($urandom), 29'h1000_0000};
                endcase
            end
        end
        foreach (vals[i]) write_reg(scf_pkg::REG_IDX_W'(i), vals[i]);
    endtask

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin : result_sink
        int hold;
        hold = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                hold = pick_gap(rx_busy);
                m_tready <= (hold == 0);
                if (hold > 0) hold--;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_pair(m_tdata);
    end

    initial begin : watchdog
        #5ms;
        $display("** stereo_crossfeed_svf_shelf: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [SAMPLE_W-1:0] l, r;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: near pass-through, field extremes and bypass
        send_pair(24'h000000, 24'h000000, 1'b0);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_pair(24'h800000, 24'h800000, 1'b0);
        send_pair(24'h7FFFFF, 24'h800000, 1'b0);
        send_pair(24'h800000, 24'h7FFFFF, 1'b0);
        send_pair(24'hFFFFFF, 24'h000001, 1'b0);
        send_pair(24'h123456, 24'hFEDCBA, 1'b1);
        send_pair(24'h7FFFFF, 24'h800000, 1'b1);
        send_pair(24'h800000, 24'h7FFFFF, 1'b1);
        wait_drain();

        // gains above unity (junk in the upper bits), coefficients at the rails
        write_reg(scf_pkg::REG_GAIN_IN,  32'hFFFF_FFFF);
        write_reg(scf_pkg::REG_GAIN_OUT, 32'hFFFF_FFFF);
        write_reg(scf_pkg::REG_COEF_A0,  32'h7FFF_FFFF);
        write_reg(scf_pkg::REG_COEF_A1,  32'h8000_0000);
        write_reg(scf_pkg::REG_COEF_A2,  32'h7FFF_FFFF);
        write_reg(scf_pkg::REG_MIX_B0,   32'h8000_0000);
        write_reg(scf_pkg::REG_MIX_B1,   32'h7FFF_FFFF);
        write_reg(scf_pkg::REG_MIX_B2,   32'h8000_0000);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_pair(24'h800000, 24'h800000, 1'b0);
        send_pair(24'h7FFFFF, 24'h800000, 1'b0);
        send_pair(24'h800000, 24'h7FFFFF, 1'b0);
        send_pair(24'h400000, 24'hC00000, 1'b0);
        send_pair(24'h7FFFFF, 24'h800000, 1'b1);
        send_pair(24'h000001, 24'hFFFFFF, 1'b0);
        send_pair(24'h000000, 24'h000000, 1'b0);
        wait_drain();

        // zero gains with saturated integrators left over
        write_reg(scf_pkg::REG_GAIN_IN,  32'h0000_0000);
        write_reg(scf_pkg::REG_GAIN_OUT, 32'h0000_0000);
        send_pair(24'h7FFFFF, 24'h800000, 1'b0);
        send_pair(24'h800000, 24'h7FFFFF, 1'b1);
        send_pair(24'h123456, 24'h654321, 1'b0);
        send_pair(24'h000000, 24'h000000, 1'b0);
        wait_drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            load_settings(ph % 3);
            tx_busy = (ph == 0) ? 1'b0 : (ph == 2) ? 1'b1 : ($urandom_range(0, 2) != 0);
            rx_busy = (ph == 0) ? 1'b0 : (ph == 2) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (ph == 1) long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2) wait_drain();
                l = rand_sample();
                // correlated channels half the time, as real program material
                if ($urandom_range(0, 1) == 0)
                    r = l + SAMPLE_W'($urandom_range(0, 512)) - SAMPLE_W'(256);
                else
                    r = rand_sample();
                send_pair(l, r, $urandom_range(0, 99) < 15);
            end
            wait_drain();
        end

        sb.errors += sb.pending_q.size();
        if (sb.errors == 0) begin
            $display("** stereo_crossfeed_svf_shelf: PASSED **");
        end else begin
            $display("** stereo_crossfeed_svf_shelf: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/scf_pkg.sv
sv/scf_ctrl.sv
sv/scf_datapath.sv
sv/stereo_crossfeed_svf_shelf.sv
tb/tb_stereo_crossfeed_svf_shelf.sv
